FILE: rtl/core/mqfb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the queue bank.
`default_nettype none

package mqfb_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_NUM_QUEUES  = 6;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_HANDLE_BITS = 16;

	// Fixed field widths
	localparam int OP_W       = 2;
	localparam int QID_W      = 3;
	localparam int RC_W       = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam int BATCH_W    = 4;
	localparam int POLL_W     = 3;
	localparam int CUR_W      = POLL_W + 1;

	// Batch limit and register reset values
	localparam logic [BATCH_W-1:0] BATCH_CAP       = 4'd8;
	localparam logic [BATCH_W-1:0] MAX_BATCH_RST   = 4'd8;
	localparam logic [POLL_W-1:0]  POLL_FIRST_RST  = 3'd0;
	localparam logic [POLL_W-1:0]  POLL_LAST_RST   = 3'd5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_POLL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_BATCH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_POLL_FIRST = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_POLL_LAST  = 2'd2;

	// Result codes
	typedef enum logic [RC_W-1:0] {
		RC_OK    = 2'd0,
		RC_FULL  = 2'd1,
		RC_EMPTY = 2'd2,
		RC_BAD   = 2'd3
	} rc_t;

	// Which result the datapath loads into the output register
	typedef enum logic [2:0] {
		LD_NONE,
		LD_BAD,
		LD_FULL,
		LD_PUSH_OK,
		LD_POP_EMPTY,
		LD_POP_DATA,
		LD_POLL_DATA,
		LD_POLL_EMPTY
	} ld_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    push_wr;
		logic    rd_head;
		logic    poll_init;
		logic    next_q;
		ld_sel_t ld;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            q_valid;
		logic            full;
		logic            empty;
		logic            in_range;
		logic            can_drain;
		logic            drained_any;
		logic            out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/multi_queue_fifo_bank_batch_drain.sv
// Top level of the bank of handle ring FIFOs with push, pop and batch poll.
//
// Input stream (s_axis): tuser carries the opcode (push, pop, poll), tdata the
// queue index and the handle. Each transfer is one operation.
// Output stream (m_axis): one result per push or pop, one result per handle
// drained by a poll (or one empty result when a poll drains nothing); tuser
// carries the result code and tlast marks the final result of an operation.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 max batch,
// 1 first polled queue, 2 last polled queue); write only while idle.
// Sequencing: one operation at a time (s_axis_tready is high only while idle). A
// push loads its result in the execute state after the transfer is captured; a
// pop first reads the queue head (the handle memory read is registered) and then
// loads the result. A poll starts at the first queue, steps queue by queue, and
// reads and then loads each drained handle in turn through the single read port
// of the handle memory; past the range it loads one empty result if none drained.
// Reset: all queues empty, max batch 8, poll range queues 0 to 5. Handle
// memory contents are not cleared; no slot is read before it is written.
// Stall: the output register holds a result until taken; while it is full the
// sequencer waits before loading the next result, and s_axis_tready is low until idle.
`default_nettype none

module multi_queue_fifo_bank_batch_drain #(
	parameter int NUM_QUEUES    = mqfb_pkg::DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH   = mqfb_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_BITS   = mqfb_pkg::DEF_HANDLE_BITS,
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
	localparam int S_TDATA_W    = ((mqfb_pkg::QID_W + HANDLE_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W    = ((mqfb_pkg::QID_W + HANDLE_BITS + CNT_W + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [S_TDATA_W-1:0]            s_axis_tdata,  // queue_id, entry_handle
	input  wire logic [mqfb_pkg::OP_W-1:0]       s_axis_tuser,  // opcode
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [M_TDATA_W-1:0]                 m_axis_tdata,  // source_queue, handle_out, queue_count
	output logic [mqfb_pkg::RC_W-1:0]            m_axis_tuser,  // result_code
	output logic                                 m_axis_tlast,  // last_result
	input  wire logic                            cfg_we,
	input  wire logic [mqfb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [mqfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import mqfb_pkg::*;

	dp_stat_t               stat;
	dp_cmd_t                cmd;
	rc_t                    out_code;
	logic [QID_W-1:0]       out_queue;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [CNT_W-1:0]       out_count;

	mqfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mqfb_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_opcode   (s_axis_tuser),
		.in_queue_id (s_axis_tdata[QID_W-1:0]),
		.in_handle   (s_axis_tdata[QID_W +: HANDLE_BITS]),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_code    (out_code),
		.out_queue   (out_queue),
		.out_handle  (out_handle),
		.out_count   (out_count),
		.out_last    (m_axis_tlast)
	);

	// Pack the result transfer
	assign m_axis_tdata = M_TDATA_W'({out_count, out_handle, out_queue});
	assign m_axis_tuser = out_code;

endmodule

`default_nettype wire

FILE: rtl/core/mqfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mqfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mqfb_dp.sv
// Datapath: queue pointers and counts, handle memory, config registers, result register.
`default_nettype none

module mqfb_dp #(
	parameter int NUM_QUEUES  = mqfb_pkg::DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH = mqfb_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_BITS = mqfb_pkg::DEF_HANDLE_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mqfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [mqfb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic [mqfb_pkg::OP_W-1:0]           in_opcode,
	input  wire logic [mqfb_pkg::QID_W-1:0]          in_queue_id,
	input  wire logic [HANDLE_BITS-1:0]              in_handle,
	input  wire mqfb_pkg::dp_cmd_t                   cmd,
	output mqfb_pkg::dp_stat_t                       stat,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output mqfb_pkg::rc_t                            out_code,
	output logic [mqfb_pkg::QID_W-1:0]               out_queue,
	output logic [HANDLE_BITS-1:0]                   out_handle,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]         out_count,
	output logic                                     out_last
);

	import mqfb_pkg::*;

	localparam int QI_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	// Configuration registers
	logic [BATCH_W-1:0] max_batch_q;
	logic [POLL_W-1:0]  poll_first_q;
	logic [POLL_W-1:0]  poll_last_q;

	// Operation registers
	logic [OP_W-1:0]        op_q;
	logic [CUR_W-1:0]       cur_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [BATCH_W-1:0]     taken_q;
	logic                   any_q;

	// Per-queue ring state
	logic [PTR_W-1:0] head_q  [NUM_QUEUES];
	logic [PTR_W-1:0] tail_q  [NUM_QUEUES];
	logic [CNT_W-1:0] count_q [NUM_QUEUES];

	// Result register
	logic                   out_valid_q;
	rc_t                    out_code_q;
	logic [QID_W-1:0]       out_queue_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [CNT_W-1:0]       out_count_q;
	logic                   out_last_q;

	logic [QI_W-1:0]        idx;
	logic [PTR_W-1:0]       cur_head;
	logic [PTR_W-1:0]       cur_tail;
	logic [CNT_W-1:0]       cur_count;
	logic [BATCH_W-1:0]     batch;
	logic                   q_valid;
	logic                   can_drain;
	logic                   later;
	logic                   more;
	logic                   out_free;
	logic [ADDR_W-1:0]      waddr;
	logic [ADDR_W-1:0]      raddr;
	logic [HANDLE_BITS-1:0] rdata;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [QI_W-1:0] q,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Select the current queue's state
	assign idx       = cur_q[QI_W-1:0];
	assign cur_head  = head_q[idx];
	assign cur_tail  = tail_q[idx];
	assign cur_count = count_q[idx];
	assign batch     = (max_batch_q > BATCH_CAP) ? BATCH_CAP : max_batch_q;
	assign q_valid   = cur_q < CUR_W'(NUM_QUEUES);
	assign can_drain = (cur_count != '0) && (taken_q < batch);
	assign out_free  = !out_valid_q || out_ready;

	// Look for any later queue in the poll range that still holds handles
	always_comb begin
		later = 1'b0;
		for (int j = 0; j < NUM_QUEUES; j++) begin
			if ((CUR_W'(j) > cur_q) && (CUR_W'(j) <= {1'b0, poll_last_q}) &&
					(count_q[j] != '0)) begin
				later = 1'b1;
			end
		end
	end

	assign more = can_drain || later;

	// Status to the controller
	always_comb begin
		stat.op          = op_q;
		stat.q_valid     = q_valid;
		stat.full        = cur_count == CNT_W'(QUEUE_DEPTH);
		stat.empty       = cur_count == '0;
		stat.in_range    = q_valid && (cur_q <= {1'b0, poll_last_q});
		stat.can_drain   = can_drain;
		stat.drained_any = any_q;
		stat.out_free    = out_free;
	end

	// Handle memory
	assign waddr = slot_addr(idx, cur_tail);
	assign raddr = slot_addr(idx, cur_head);

	mqfb_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (cmd.push_wr),
		.waddr (waddr),
		.wdata (handle_q),
		.re    (cmd.rd_head),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Configuration, operation and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_batch_q  <= MAX_BATCH_RST;
			poll_first_q <= POLL_FIRST_RST;
			poll_last_q  <= POLL_LAST_RST;
			cur_q        <= '0;
			taken_q      <= '0;
			any_q        <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			// Register writes
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MAX_BATCH:  max_batch_q  <= cfg_wdata;
					REG_POLL_FIRST: poll_first_q <= cfg_wdata[POLL_W-1:0];
					REG_POLL_LAST:  poll_last_q  <= cfg_wdata[POLL_W-1:0];
					default: ;
				endcase
			end
			// Latch a new operation
			if (cmd.capture) begin
				cur_q <= CUR_W'(in_queue_id);
			end
			// Start a poll at the first queue
			if (cmd.poll_init) begin
				cur_q   <= CUR_W'(poll_first_q);
				taken_q <= '0;
				any_q   <= 1'b0;
			end
			// Advance the poll to the next queue
			if (cmd.next_q) begin
				cur_q   <= cur_q + 1'b1;
				taken_q <= '0;
			end
			// Append at the tail
			if (cmd.push_wr) begin
				tail_q[idx]  <= ptr_next(cur_tail);
				count_q[idx] <= cur_count + 1'b1;
			end
			// Remove the head
			if (cmd.rd_head) begin
				head_q[idx]  <= ptr_next(cur_head);
				count_q[idx] <= cur_count - 1'b1;
				taken_q      <= taken_q + 1'b1;
				any_q        <= 1'b1;
			end
		end
	end

	// Operation payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_opcode;
			handle_q <= in_handle;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld != LD_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		unique case (cmd.ld)
			LD_BAD: begin
				out_code_q   <= RC_BAD;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= '0;
				out_count_q  <= '0;
				out_last_q   <= 1'b1;
			end
			LD_FULL: begin
				out_code_q   <= RC_FULL;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= '0;
				out_count_q  <= cur_count;
				out_last_q   <= 1'b1;
			end
			LD_PUSH_OK: begin
				out_code_q   <= RC_OK;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= '0;
				out_count_q  <= cur_count + 1'b1;
				out_last_q   <= 1'b1;
			end
			LD_POP_EMPTY: begin
				out_code_q   <= RC_EMPTY;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= '0;
				out_count_q  <= '0;
				out_last_q   <= 1'b1;
			end
			LD_POP_DATA: begin
				out_code_q   <= RC_OK;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= rdata;
				out_count_q  <= cur_count;
				out_last_q   <= 1'b1;
			end
			LD_POLL_DATA: begin
				out_code_q   <= RC_OK;
				out_queue_q  <= cur_q[QID_W-1:0];
				out_handle_q <= rdata;
				out_count_q  <= cur_count;
				out_last_q   <= !more;
			end
			LD_POLL_EMPTY: begin
				out_code_q   <= RC_EMPTY;
				out_queue_q  <= '0;
				out_handle_q <= '0;
				out_count_q  <= '0;
				out_last_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_code   = out_code_q;
	assign out_queue  = out_queue_q;
	assign out_handle = out_handle_q;
	assign out_count  = out_count_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/mqfb_ctrl.sv
// Controller: sequences push, pop and poll operations over the datapath.
`default_nettype none

module mqfb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mqfb_pkg::dp_stat_t stat,
	output mqfb_pkg::dp_cmd_t       cmd
);

	import mqfb_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE      = 6'b000001,
		S_EXEC      = 6'b000010,
		S_POP_RD    = 6'b000100,
		S_SCAN      = 6'b001000,
		S_POLL_RD   = 6'b010000,
		S_POLL_NONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.ld  = LD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					OP_PUSH: begin
						if (stat.out_free) begin
							state_d = S_IDLE;
							if (!stat.q_valid) begin
								cmd.ld = LD_BAD;
							end else if (stat.full) begin
								cmd.ld = LD_FULL;
							end else begin
								cmd.push_wr = 1'b1;
								cmd.ld      = LD_PUSH_OK;
							end
						end
					end
					OP_POP: begin
						if (!stat.q_valid) begin
							if (stat.out_free) begin
								cmd.ld  = LD_BAD;
								state_d = S_IDLE;
							end
						end else if (stat.empty) begin
							if (stat.out_free) begin
								cmd.ld  = LD_POP_EMPTY;
								state_d = S_IDLE;
							end
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = S_POP_RD;
						end
					end
					OP_POLL: begin
						cmd.poll_init = 1'b1;
						state_d       = S_SCAN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_POP_RD: begin
				if (stat.out_free) begin
					cmd.ld  = LD_POP_DATA;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!stat.in_range) begin
					state_d = stat.drained_any ? S_IDLE : S_POLL_NONE;
				end else if (stat.can_drain) begin
					cmd.rd_head = 1'b1;
					state_d     = S_POLL_RD;
				end else begin
					cmd.next_q = 1'b1;
				end
			end
			S_POLL_RD: begin
				if (stat.out_free) begin
					cmd.ld  = LD_POLL_DATA;
					state_d = S_SCAN;
				end
			end
			S_POLL_NONE: begin
				if (stat.out_free) begin
					cmd.ld  = LD_POLL_EMPTY;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/mqfb_checker.sv
// Port-level checker for the queue bank, bound to the top level.
`default_nettype none

module mqfb_checker #(
	parameter int NUM_QUEUES  = mqfb_pkg::DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH = mqfb_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_BITS = mqfb_pkg::DEF_HANDLE_BITS,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int M_TDATA_W  = ((mqfb_pkg::QID_W + HANDLE_BITS + CNT_W + 7) / 8) * 8
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [M_TDATA_W-1:0]       m_axis_tdata,
	input wire logic [mqfb_pkg::RC_W-1:0]  m_axis_tuser,
	input wire logic                       m_axis_tlast
);

	import mqfb_pkg::*;

	localparam int HI_W = M_TDATA_W - QID_W;

	// One operation at a time: the input closes after each transfer
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on back-to-back cycles");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// Bad index results are final and carry no handle or count
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == RC_BAD) |->
			m_axis_tlast && (m_axis_tdata[M_TDATA_W-1:QID_W] == HI_W'(0)))
		else $error("bad index result malformed");

	// Empty results are final and carry no handle or count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == RC_EMPTY) |->
			m_axis_tlast && (m_axis_tdata[M_TDATA_W-1:QID_W] == HI_W'(0)))
		else $error("empty result malformed");

	// A full result reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == RC_FULL) |->
			m_axis_tlast && (m_axis_tdata[QID_W +: HANDLE_BITS] == HANDLE_BITS'(0)) &&
			(m_axis_tdata[QID_W + HANDLE_BITS +: CNT_W] == CNT_W'(QUEUE_DEPTH)))
		else $error("full result malformed");

endmodule

bind multi_queue_fifo_bank_batch_drain mqfb_checker #(
	.NUM_QUEUES  (NUM_QUEUES),
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.HANDLE_BITS (HANDLE_BITS)
) u_mqfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the handle queue bank: push, pop and batch poll streams.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mqfb_pkg::*;

	localparam int NQ  = DEF_NUM_QUEUES;
	localparam int QD  = DEF_QUEUE_DEPTH;
	localparam int HB  = DEF_HANDLE_BITS;
	localparam int CW  = $clog2(QD + 1);
	localparam int S_W = ((QID_W + HB + 7) / 8) * 8;
	localparam int M_W = ((QID_W + HB + CW + 7) / 8) * 8;

	// Opcode with no meaning to the block
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		rc_t              code;
		logic [QID_W-1:0] src;
		logic [HB-1:0]    handle;
		logic [CW-1:0]    count;
		logic             last;
	} bank_result_t;

	// Mirror of the queue bank; holds the results still owed by the block
	class queue_bank_tracker;
		logic [HB-1:0] slots [NQ][QD];
		int unsigned   head [NQ];
		int unsigned   tail [NQ];
		int unsigned   fill [NQ];
		int unsigned   max_batch;
		int unsigned   poll_first;
		int unsigned   poll_last;
		bank_result_t  owed_results [$];
		int unsigned   mismatches;

		function new();
			foreach (head[i]) begin
				head[i] = 0;
				tail[i] = 0;
				fill[i] = 0;
			end
			max_batch  = MAX_BATCH_RST;
			poll_first = POLL_FIRST_RST;
			poll_last  = POLL_LAST_RST;
			mismatches = 0;
		endfunction

		function void write_reg(input logic [CFG_ADDR_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MAX_BATCH:  max_batch  = val;
				REG_POLL_FIRST: poll_first = val[POLL_W-1:0];
				REG_POLL_LAST:  poll_last  = val[POLL_W-1:0];
				default: ;
			endcase
		endfunction

		function void owe(input rc_t code, input int unsigned q, input logic [HB-1:0] h,
				input int unsigned cnt, input logic last);
			bank_result_t r;
			r.code   = code;
			r.src    = q[QID_W-1:0];
			r.handle = h;
			r.count  = cnt[CW-1:0];
			r.last   = last;
			owed_results.push_back(r);
		endfunction

		function logic [HB-1:0] take_head(input int unsigned q);
			logic [HB-1:0] v;
			v = slots[q][head[q]];
			head[q] = (head[q] + 1) % QD;
			fill[q]--;
			return v;
		endfunction

		// Update the mirror for one accepted operation and queue its results
		function void apply_op(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
				input logic [HB-1:0] h);
			int unsigned batch;
			int unsigned total;
			int unsigned n;
			int unsigned take;
			logic [HB-1:0] v;
			if (op == OP_PUSH || op == OP_POP) begin
				if (qid >= NQ) begin
					owe(RC_BAD, qid, '0, 0, 1'b1);
				end else if (op == OP_PUSH) begin
					if (fill[qid] >= QD) begin
						owe(RC_FULL, qid, '0, fill[qid], 1'b1);
					end else begin
						slots[qid][tail[qid]] = h;
						tail[qid] = (tail[qid] + 1) % QD;
						fill[qid]++;
						owe(RC_OK, qid, '0, fill[qid], 1'b1);
					end
				end else if (fill[qid] == 0) begin
					owe(RC_EMPTY, qid, '0, 0, 1'b1);
				end else begin
					v = take_head(qid);
					owe(RC_OK, qid, v, fill[qid], 1'b1);
				end
			end else if (op == OP_POLL) begin
				batch = (max_batch > BATCH_CAP) ? BATCH_CAP : max_batch;
				// count the drain first so the final result can be marked
				total = 0;
				for (int unsigned i = poll_first; i <= poll_last && i < NQ; i++)
					total += (fill[i] > batch) ? batch : fill[i];
				n = 0;
				for (int unsigned i = poll_first; i <= poll_last && i < NQ; i++) begin
					take = (fill[i] > batch) ? batch : fill[i];
					for (int unsigned j = 0; j < take; j++) begin
						n++;
						v = take_head(i);
						owe(RC_OK, i, v, fill[i], n == total);
					end
				end
				if (total == 0)
					owe(RC_EMPTY, 0, '0, 0, 1'b1);
			end
		endfunction

		// Compare one result transfer with the oldest owed result
		function void compare_result(input logic [RC_W-1:0] code, input logic [QID_W-1:0] src,
				input logic [HB-1:0] h, input logic [CW-1:0] cnt, input logic last);
			bank_result_t want;
			if (owed_results.size() == 0) begin
				$error("unexpected result: code %0d queue %0d handle %0h count %0d last %0b",
					code, src, h, cnt, last);
				mismatches++;
				return;
			end
			want = owed_results.pop_front();
			if (code !== want.code) begin
				$error("result_code: expected %0d, got %0d", want.code, code);
				mismatches++;
			end
			if (src !== want.src) begin
				$error("source_queue: expected %0d, got %0d", want.src, src);
				mismatches++;
			end
			if (h !== want.handle) begin
				$error("handle_out: expected %0h, got %0h", want.handle, h);
				mismatches++;
			end
			if (cnt !== want.count) begin
				$error("queue_count: expected %0d, got %0d", want.count, cnt);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_result: expected %0b, got %0b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_W-1:0]        s_axis_tdata  = '0;  // queue_id, entry_handle
	logic [OP_W-1:0]       s_axis_tuser  = OP_PUSH;  // opcode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_W-1:0]        m_axis_tdata;  // source_queue, handle_out, queue_count
	logic [RC_W-1:0]       m_axis_tuser;  // result_code
	logic                  m_axis_tlast;  // last_result
	logic                  cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = REG_MAX_BATCH;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

	queue_bank_tracker tracker;
	int unsigned       send_idle_pct = 11;
	int unsigned       recv_idle_pct = 55;
	bit                hold_request  = 1'b0;
	logic [QID_W-1:0]  hot_queue     = '0;

	multi_queue_fifo_bank_batch_drain uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one operation, idling at random first; return after its transfer
	task automatic send_op(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
			input logic [HB-1:0] h);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_W - QID_W - HB){1'b0}}, h, qid};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		tracker.apply_op(op, qid, h);
	endtask

	// Mostly well-formed traffic on valid queues, with some bad indexes and unused opcodes
	task automatic send_random();
		int unsigned      pick;
		logic [OP_W-1:0]  op;
		logic [QID_W-1:0] qid;
		logic [HB-1:0]    h;
		pick = $urandom_range(99);
		h    = HB'($urandom);
		qid  = $urandom_range(1) ? hot_queue : QID_W'($urandom_range(NQ - 1));
		if (pick < 52) begin
			op = OP_PUSH;
		end else if (pick < 74) begin
			op = OP_POP;
		end else if (pick < 88) begin
			op  = OP_POLL;
			qid = QID_W'($urandom_range(7));
		end else if (pick < 96) begin
			op  = $urandom_range(1) ? OP_PUSH : OP_POP;
			qid = QID_W'($urandom_range(7, NQ));
		end else begin
			op  = OP_UNUSED;
			qid = QID_W'($urandom_range(7));
		end
		send_op(op, qid, h);
	endtask

	// Stop offering, wait for every owed result, then let the block settle
	task automatic drain_bank();
		s_axis_tvalid <= 1'b0;
		while (tracker.owed_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write all three registers in turn while idle
	task automatic program_regs(input logic [BATCH_W-1:0] mb, input logic [POLL_W-1:0] pf,
			input logic [POLL_W-1:0] pl);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_MAX_BATCH;
		cfg_wdata <= mb;
		@(posedge clk);
		cfg_addr  <= REG_POLL_FIRST;
		cfg_wdata <= {1'b0, pf};
		@(posedge clk);
		cfg_addr  <= REG_POLL_LAST;
		cfg_wdata <= {1'b0, pl};
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(REG_MAX_BATCH, mb);
		tracker.write_reg(REG_POLL_FIRST, {1'b0, pf});
		tracker.write_reg(REG_POLL_LAST, {1'b0, pl});
	endtask

	// Empty queues, bad indexes, unused opcode, a full queue and a drain at reset settings
	task automatic run_directed();
		send_op(OP_POP, 3'd1, 16'h0000);
		send_op(OP_POLL, 3'd0, 16'h0000);
		send_op(OP_PUSH, 3'd7, 16'hFFFF);
		send_op(OP_POP, 3'd6, 16'h0000);
		send_op(OP_UNUSED, 3'd3, 16'h1234);
		send_op(OP_PUSH, 3'd0, 16'h0000);
		send_op(OP_PUSH, 3'd0, 16'hFFFF);
		for (int i = 0; i < QD - 1; i++)
			send_op(OP_PUSH, 3'd0, HB'($urandom));
		send_op(OP_POP, 3'd0, 16'h0000);
		send_op(OP_POLL, 3'd5, 16'h0000);
	endtask

	// Stimulus: reset, directed part, then phases of random traffic
	initial begin
		logic [BATCH_W-1:0] mb_set [9];
		logic [POLL_W-1:0]  pf_set [9];
		logic [POLL_W-1:0]  pl_set [9];
		mb_set = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd0, 4'd8};
		pf_set = '{3'd0, 3'd0, 3'd2,  3'd0, 3'd5, 3'd7, 3'd0, 3'd0, 3'd0};
		pl_set = '{3'd5, 3'd7, 3'd4,  3'd7, 3'd1, 3'd7, 3'd0, 3'd0, 3'd5};
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 9; p++) begin
			drain_bank();
			if (p == 3) begin
				send_idle_pct = 55;
				recv_idle_pct = 11;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 7)
				program_regs(BATCH_W'($urandom_range(15)), POLL_W'($urandom_range(7)),
					POLL_W'($urandom_range(7)));
			else
				program_regs(mb_set[p], pf_set[p], pl_set[p]);
			hot_queue = QID_W'($urandom_range(NQ - 1));
			// back up the output while the sender keeps offering
			if (p == 1)
				hold_request = 1'b1;
			repeat (26) send_random();
		end
		drain_bank();
		if (tracker.mismatches == 0) begin
			$display("** multi_queue_fifo_bank_batch_drain: PASSED **");
		end else begin
			$display("** multi_queue_fifo_bank_batch_drain: FAILED **");
		end
		$finish;
	end

	// Result side: check each transfer, then pick the next ready value
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tracker.compare_result(m_axis_tuser, m_axis_tdata[QID_W-1:0],
					m_axis_tdata[QID_W+HB-1:QID_W], m_axis_tdata[QID_W+HB+CW-1:QID_W+HB],
					m_axis_tlast);
			if (hold_request) begin
				hold_left    = 250;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog for a hung run
	initial begin
		#10_000_000;
		$display("** multi_queue_fifo_bank_batch_drain: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/mqfb_pkg.sv
rtl/core/mqfb_ram.sv
rtl/core/mqfb_dp.sv
rtl/core/mqfb_ctrl.sv
rtl/core/multi_queue_fifo_bank_batch_drain.sv
rtl/core/mqfb_checker.sv
bench/testbench.sv
